>>> src/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

  localparam int VALUE_WIDTH_DEF = 31;
  localparam int FIRST_PRIME     = 2;

  // status from the serial remainder unit back to the sequencer
  typedef struct packed {
    logic done;   // one-cycle pulse, remainder valid
    logic zero;   // remainder is zero (qualified by done)
  } rem_stat_t;

endpackage

`default_nettype wire

>>> src/tdpt_rem.sv
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
module tdpt_rem
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output rem_stat_t                   stat
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] num_r;
  logic [VALUE_WIDTH-1:0] div_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] rem_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;

  always_comb begin
    trial = {rem_r, num_r[VALUE_WIDTH-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[VALUE_WIDTH-1:0];
    end else begin
      rem_nxt = trial[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VALUE_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[VALUE_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

`default_nettype wire

>>> src/trial_division_prime_tracker.sv
// Trial-division prime tracker.
// Input channel (in_*): one candidate word per item, unsigned, in the low
// VALUE_WIDTH bits of in_tdata. Output channel (out_*): one result word per
// item: bit 0 is the prime flag, the bits above hold the most recent prime.
// in_tready is high only while no candidate is under test; a finished result
// waits in the output register, so the next candidate is taken meanwhile.
// Each candidate passes from S_IDLE to S_CHECK, then through S_DIV and
// back to S_CHECK once per divisor tried, and ends in S_DONE. The search
// stops at the first divisor that leaves no remainder, or in S_CHECK for
// primes and values below 2. Divisors run from 2 while their square does
// not exceed the candidate. A large prime at the default width tries about
// 46341 divisors. Each trial runs the bit-serial remainder unit, one
// dividend bit per cycle. Items are processed one at a time.
// Reset clears the handshake state and sets the tracked prime to 2.
// If the receiver stalls, the result holds in the output register and a
// second finished result waits in the sequencer until the first is taken.
`default_nettype none

module trial_division_prime_tracker
  import tdpt_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [(VALUE_WIDTH+7)/8*8-1:0] in_tdata,  // [VALUE_WIDTH-1:0] candidate
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [(VALUE_WIDTH+8)/8*8-1:0] out_tdata  // [0] is_prime, [VALUE_WIDTH:1] last_prime
);

  localparam int OUT_DW = ((VALUE_WIDTH + 8) / 8) * 8;
  localparam int SW     = VALUE_WIDTH + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic [SW-1:0]          sq_r;
  logic                   prime_r;
  logic [VALUE_WIDTH-1:0] tracked_r;
  logic                   out_valid_r;
  logic [OUT_DW-1:0]      out_data_r;
  logic                   rem_start;
  logic                   small_n;
  logic                   sq_over;
  logic                   out_free;
  rem_stat_t              rem_stat;

  assign small_n   = (n_r < VALUE_WIDTH'(FIRST_PRIME));
  assign sq_over   = (sq_r > {2'b00, n_r});
  assign rem_start = (state_r == S_CHECK) && !small_n && !sq_over;
  assign out_free  = !out_valid_r || out_tready;

  tdpt_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .dividend(n_r),
    .divisor (d_r),
    .stat    (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tracked_r   <= VALUE_WIDTH'(FIRST_PRIME);
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (small_n || sq_over) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_stat.done) begin
            if (rem_stat.zero) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (prime_r) begin
              tracked_r <= n_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_r  <= in_tdata[VALUE_WIDTH-1:0];
          d_r  <= VALUE_WIDTH'(FIRST_PRIME);
          sq_r <= SW'(FIRST_PRIME * FIRST_PRIME);
        end
      end
      S_CHECK: begin
        if (small_n) begin
          prime_r <= 1'b0;
        end else if (sq_over) begin
          prime_r <= 1'b1;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            prime_r <= 1'b0;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_r <= sq_r + {1'b0, d_r, 1'b1};
            d_r  <= d_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_r <= OUT_DW'({(prime_r ? n_r : tracked_r), prime_r});
        end
      end
      default: begin
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.done |-> state_r == S_DIV)
    else $error("remainder finished outside divide phase");

  a_last_prime_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VALUE_WIDTH:1] >= VALUE_WIDTH'(FIRST_PRIME))
    else $error("reported prime below two");

  a_prime_not_small: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && prime_r) |-> !small_n)
    else $error("candidate below two flagged prime");

  a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK || state_r == S_DIV) |-> d_r >= VALUE_WIDTH'(FIRST_PRIME))
    else $error("trial divisor below two");
`endif

endmodule

`default_nettype wire
